@@ src/vea_pkg.sv @@
// Package with the types and constants shared by the adjacency builder modules.
`timescale 1ns / 1ps

package vea_pkg;

    localparam int OP_W       = 2;
    localparam int VERTEX_W   = 11;
    localparam int RANK_W     = 12;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 13;
    localparam int ELEM_W     = 11;
    localparam int NPE_W      = 5;
    localparam int VCOUNT_W   = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 3;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_BASED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NODES        = 2'd2;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 11'd1024;
    localparam logic [NPE_W-1:0]    NPE_RESET    = 5'd4;
    localparam logic [NPE_W-1:0]    NPE_MIN      = 5'd2;

    typedef struct packed {
        logic [VCOUNT_W-1:0] vertex_count;
        logic                one_based;
        logic [NPE_W-1:0]    elem_nodes;
    } cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  degree;
        logic [COUNT_W-1:0]  start_position;
        logic [ELEM_W-1:0]   element;
        logic                found;
    } result_t;

endpackage

@@ src/vertex_element_adjacency_builder.sv @@
// Top level of the vertex-to-element adjacency builder with its registers and memories.
//
// Channel   Direction  Handshake          Contents
// s_*       in         s_tvalid/s_tready  one item: load, query or clear
// m_*       out        m_tvalid/m_tready  one result item for each input item
// cfg_*     in         cfg_valid/cfg_ready register index and write data
//
// The first query after a stored load, a clear or a register write first rebuilds the table:
// it clears the offset memory, counts the used entries per vertex in a first pass over the
// connectivity memory, sums the offsets and places each used entry's element in the adjacency
// memory in a second pass over the connectivity memory. Reset needs no clearing pass. A waiting
// result is held in the output register while the next item is taken.
`timescale 1ns / 1ps

module vertex_element_adjacency_builder #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_ENTRIES  = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // vertex[10:0], rank[22:11]
    input  logic [vea_pkg::S_TDATA_W-1:0]   s_tdata,
    // op[1:0]
    input  logic [vea_pkg::OP_W-1:0]        s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // degree[12:0], start_position[25:13], element[36:26]
    output logic [vea_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[1:0], found[2]
    output logic [vea_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vea_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vea_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import vea_pkg::*;

    localparam int EAW = $clog2(MAX_ENTRIES);
    localparam int OAW = $clog2(MAX_VERTICES + 2);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);

    cfg_t                cfg_reg, cfg_next;
    logic                cfg_wr;
    result_t             res;

    logic                conn_we, conn_re;
    logic [EAW-1:0]      conn_waddr, conn_raddr;
    logic [VERTEX_W-1:0] conn_wdata, conn_rdata;
    logic                off_we, off_re;
    logic [OAW-1:0]      off_waddr, off_raddr;
    logic [CW-1:0]       off_wdata, off_rdata;
    logic                adj_we, adj_re;
    logic [EAW-1:0]      adj_waddr, adj_raddr;
    logic [ELEM_W-1:0]   adj_wdata, adj_rdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        cfg_wr   = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_VERTEX_COUNT:
                begin
                    cfg_next.vertex_count = cfg_data;
                    cfg_wr                = 1'b1;
                end
                CFG_ONE_BASED:
                begin
                    cfg_next.one_based = cfg_data[0];
                    cfg_wr             = 1'b1;
                end
                CFG_NODES:
                begin
                    cfg_next.elem_nodes = cfg_data[NPE_W-1:0];
                    cfg_wr              = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vertex_count <= VCOUNT_RESET;
            cfg_reg.one_based    <= 1'b0;
            cfg_reg.elem_nodes   <= NPE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vea_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_ENTRIES  (MAX_ENTRIES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cfg_wr     (cfg_wr),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_vertex  (s_tdata[VERTEX_W-1:0]),
        .in_rank    (s_tdata[VERTEX_W +: RANK_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (res),
        .conn_we    (conn_we),
        .conn_waddr (conn_waddr),
        .conn_wdata (conn_wdata),
        .conn_re    (conn_re),
        .conn_raddr (conn_raddr),
        .conn_rdata (conn_rdata),
        .off_we     (off_we),
        .off_waddr  (off_waddr),
        .off_wdata  (off_wdata),
        .off_re     (off_re),
        .off_raddr  (off_raddr),
        .off_rdata  (off_rdata),
        .adj_we     (adj_we),
        .adj_waddr  (adj_waddr),
        .adj_wdata  (adj_wdata),
        .adj_re     (adj_re),
        .adj_raddr  (adj_raddr),
        .adj_rdata  (adj_rdata)
    );

    vea_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (VERTEX_W)
    ) u_conn_ram (
        .clk   (clk),
        .we    (conn_we),
        .waddr (conn_waddr),
        .wdata (conn_wdata),
        .re    (conn_re),
        .raddr (conn_raddr),
        .rdata (conn_rdata)
    );

    vea_ram #(
        .DEPTH (MAX_VERTICES + 2),
        .WIDTH (CW)
    ) u_off_ram (
        .clk   (clk),
        .we    (off_we),
        .waddr (off_waddr),
        .wdata (off_wdata),
        .re    (off_re),
        .raddr (off_raddr),
        .rdata (off_rdata)
    );

    vea_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (ELEM_W)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .re    (adj_re),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    assign m_tdata = M_TDATA_W'({res.element, res.start_position, res.degree});
    assign m_tuser = {res.found, res.status};

endmodule

@@ src/vea_ram.sv @@
// Synchronous RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module vea_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 11,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/vea_ctrl.sv @@
// Sequencer that loads entries, builds the CSR table in memory and answers queries.
`timescale 1ns / 1ps

module vea_ctrl #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_ENTRIES  = 4096,
    localparam int EAW = $clog2(MAX_ENTRIES),
    localparam int OAW = $clog2(MAX_VERTICES + 2),
    localparam int CW  = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vea_pkg::cfg_t                 cfg,
    input  logic                          cfg_wr,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [vea_pkg::OP_W-1:0]      in_op,
    input  logic [vea_pkg::VERTEX_W-1:0]  in_vertex,
    input  logic [vea_pkg::RANK_W-1:0]    in_rank,
    output logic                          out_valid,
    input  logic                          out_ready,
    output vea_pkg::result_t              out_res,
    output logic                          conn_we,
    output logic [EAW-1:0]                conn_waddr,
    output logic [vea_pkg::VERTEX_W-1:0]  conn_wdata,
    output logic                          conn_re,
    output logic [EAW-1:0]                conn_raddr,
    input  logic [vea_pkg::VERTEX_W-1:0]  conn_rdata,
    output logic                          off_we,
    output logic [OAW-1:0]                off_waddr,
    output logic [CW-1:0]                 off_wdata,
    output logic                          off_re,
    output logic [OAW-1:0]                off_raddr,
    input  logic [CW-1:0]                 off_rdata,
    output logic                          adj_we,
    output logic [EAW-1:0]                adj_waddr,
    output logic [vea_pkg::ELEM_W-1:0]    adj_wdata,
    output logic                          adj_re,
    output logic [EAW-1:0]                adj_raddr,
    input  logic [vea_pkg::ELEM_W-1:0]    adj_rdata
);

    import vea_pkg::*;

    localparam int VCW = $clog2(MAX_VERTICES + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EXEC    = 4'd1;
    localparam logic [3:0] S_CLR     = 4'd2;
    localparam logic [3:0] S_SC_RD   = 4'd3;
    localparam logic [3:0] S_SC_OFF  = 4'd4;
    localparam logic [3:0] S_SC_WR   = 4'd5;
    localparam logic [3:0] S_PF_RD   = 4'd6;
    localparam logic [3:0] S_PF_WR   = 4'd7;
    localparam logic [3:0] S_Q_START = 4'd8;
    localparam logic [3:0] S_Q_POS   = 4'd9;
    localparam logic [3:0] S_Q_ELEM  = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    logic [3:0]          state_reg, state_next;
    logic                built_reg, built_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;

    logic [OP_W-1:0]     op_reg;
    logic [VERTEX_W-1:0] vtx_reg;
    logic [RANK_W-1:0]   rank_reg;
    logic [CW-1:0]       base_reg, base_next;
    logic [NPE_W-1:0]    k_reg, k_next;
    logic [ELEM_W-1:0]   elem_reg, elem_next;
    logic                phase_reg, phase_next;
    logic [OAW-1:0]      sv_reg, sv_next;
    logic [OAW-1:0]      oidx_reg, oidx_next;
    logic [CW-1:0]       acc_reg, acc_next;
    logic [CW-1:0]       end_reg, end_next;
    result_t             res_reg, res_next;
    result_t             out_res_reg, out_res_next;

    logic [VCW-1:0]      eff_v;
    logic [OAW-1:0]      top;
    logic [NPE_W-1:0]    npe;
    logic                item_ok;
    logic                mem_ok;
    logic                in_used;
    logic [CW-1:0]       entry_idx;
    logic                k_last;
    logic [NPE_W-1:0]    adv_k;
    logic [CW-1:0]       adv_base;
    logic [ELEM_W-1:0]   adv_elem;
    logic [OAW-1:0]      sv_sel;
    logic [CW-1:0]       sum;
    logic [CW-1:0]       q_start;
    logic [CW-1:0]       q_deg;
    logic                q_found;
    logic [31:0]         q_pos;

    function automatic logic in_range(input logic [VERTEX_W-1:0] v, input logic ob,
                                      input logic [VCW-1:0] ev);
        return (32'(v) >= 32'(ob)) && (32'(v) < 32'(ev) + 32'(ob));
    endfunction

    always_comb
    begin
        if (cfg.vertex_count == '0)
        begin
            eff_v = VCW'(1);
        end
        else if (32'(cfg.vertex_count) > MAX_VERTICES)
        begin
            eff_v = VCW'(MAX_VERTICES);
        end
        else
        begin
            eff_v = VCW'(cfg.vertex_count);
        end
    end

    assign top       = OAW'(eff_v) + OAW'(cfg.one_based);
    assign npe       = (cfg.elem_nodes < NPE_MIN) ? NPE_MIN : cfg.elem_nodes;
    assign item_ok   = in_range(vtx_reg, cfg.one_based, eff_v);
    assign mem_ok    = in_range(conn_rdata, cfg.one_based, eff_v);
    assign in_used   = (32'(base_reg) + 32'(npe)) <= 32'(cnt_reg);
    assign entry_idx = base_reg + CW'(k_reg);
    assign k_last    = (k_reg == npe - NPE_W'(1));
    assign adv_k     = k_last ? '0 : k_reg + NPE_W'(1);
    assign adv_base  = k_last ? base_reg + CW'(npe) : base_reg;
    assign adv_elem  = k_last ? elem_reg + ELEM_W'(1) : elem_reg;
    assign sv_sel    = phase_reg ? OAW'(conn_rdata) : OAW'(conn_rdata) + OAW'(1);
    assign sum       = acc_reg + off_rdata;
    assign q_start   = (vtx_reg == '0) ? '0 : off_rdata;
    assign q_deg     = end_reg - q_start;
    assign q_found   = 32'(rank_reg) < 32'(q_deg);
    assign q_pos     = 32'(q_start) + 32'(rank_reg);

    always_comb
    begin
        state_next     = state_reg;
        built_next     = built_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        base_next      = base_reg;
        k_next         = k_reg;
        elem_next      = elem_reg;
        phase_next     = phase_reg;
        sv_next        = sv_reg;
        oidx_next      = oidx_reg;
        acc_next       = acc_reg;
        end_next       = end_reg;
        res_next       = res_reg;
        out_res_next   = out_res_reg;
        in_ready       = 1'b0;
        conn_we        = 1'b0;
        conn_waddr     = EAW'(cnt_reg);
        conn_wdata     = vtx_reg;
        conn_re        = 1'b0;
        conn_raddr     = EAW'(entry_idx);
        off_we         = 1'b0;
        off_waddr      = oidx_reg;
        off_wdata      = '0;
        off_re         = 1'b0;
        off_raddr      = OAW'(vtx_reg);
        adj_we         = 1'b0;
        adj_waddr      = EAW'(off_rdata);
        adj_wdata      = elem_reg;
        adj_re         = 1'b0;
        adj_raddr      = EAW'(q_pos);

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next   = '0;
                state_next = S_DONE;
                unique case (op_reg)
                    OP_LOAD:
                    begin
                        if (!item_ok)
                        begin
                            res_next.status = STATUS_RANGE;
                        end
                        else if (32'(cnt_reg) >= MAX_ENTRIES)
                        begin
                            res_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            conn_we    = 1'b1;
                            cnt_next   = cnt_reg + CW'(1);
                            built_next = 1'b0;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (!item_ok)
                        begin
                            res_next.status = STATUS_RANGE;
                        end
                        else if (built_reg)
                        begin
                            off_re     = 1'b1;
                            state_next = S_Q_START;
                        end
                        else
                        begin
                            oidx_next  = '0;
                            state_next = S_CLR;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cnt_next   = '0;
                        built_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_CLR:
            begin
                off_we = 1'b1;
                if (oidx_reg == top)
                begin
                    base_next  = '0;
                    k_next     = '0;
                    elem_next  = '0;
                    phase_next = 1'b0;
                    state_next = S_SC_RD;
                end
                else
                begin
                    oidx_next = oidx_reg + OAW'(1);
                end
            end
            S_SC_RD:
            begin
                if (in_used)
                begin
                    conn_re    = 1'b1;
                    state_next = S_SC_OFF;
                end
                else if (!phase_reg)
                begin
                    oidx_next  = OAW'(1);
                    acc_next   = '0;
                    state_next = S_PF_RD;
                end
                else
                begin
                    built_next = 1'b1;
                    off_re     = 1'b1;
                    state_next = S_Q_START;
                end
            end
            S_SC_OFF:
            begin
                if (mem_ok)
                begin
                    sv_next    = sv_sel;
                    off_re     = 1'b1;
                    off_raddr  = sv_sel;
                    state_next = S_SC_WR;
                end
                else
                begin
                    k_next     = adv_k;
                    base_next  = adv_base;
                    elem_next  = adv_elem;
                    state_next = S_SC_RD;
                end
            end
            S_SC_WR:
            begin
                off_we    = 1'b1;
                off_waddr = sv_reg;
                off_wdata = off_rdata + CW'(1);
                if (phase_reg && (32'(off_rdata) < MAX_ENTRIES))
                begin
                    adj_we = 1'b1;
                end
                k_next     = adv_k;
                base_next  = adv_base;
                elem_next  = adv_elem;
                state_next = S_SC_RD;
            end
            S_PF_RD:
            begin
                off_re     = 1'b1;
                off_raddr  = oidx_reg;
                state_next = S_PF_WR;
            end
            S_PF_WR:
            begin
                off_we    = 1'b1;
                off_wdata = sum;
                acc_next  = sum;
                if (oidx_reg == top)
                begin
                    base_next  = '0;
                    k_next     = '0;
                    elem_next  = '0;
                    phase_next = 1'b1;
                    state_next = S_SC_RD;
                end
                else
                begin
                    oidx_next  = oidx_reg + OAW'(1);
                    state_next = S_PF_RD;
                end
            end
            S_Q_START:
            begin
                end_next = off_rdata;
                if (vtx_reg != '0)
                begin
                    off_re    = 1'b1;
                    off_raddr = OAW'(vtx_reg) - OAW'(1);
                end
                state_next = S_Q_POS;
            end
            S_Q_POS:
            begin
                res_next.degree         = COUNT_W'(q_deg);
                res_next.start_position = COUNT_W'(q_start);
                res_next.found          = q_found;
                if (q_found && (q_pos < 32'(MAX_ENTRIES)))
                begin
                    adj_re     = 1'b1;
                    state_next = S_Q_ELEM;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_Q_ELEM:
            begin
                res_next.element = adj_rdata;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_res_next   = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            built_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            built_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            built_reg     <= built_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= in_op;
            vtx_reg  <= in_vertex;
            rank_reg <= in_rank;
        end
        base_reg    <= base_next;
        k_reg       <= k_next;
        elem_reg    <= elem_next;
        sv_reg      <= sv_next;
        oidx_reg    <= oidx_next;
        acc_reg     <= acc_next;
        end_reg     <= end_next;
        res_reg     <= res_next;
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

@@ src/vea_checker.sv @@
// Port checker for the adjacency builder and its bind to the top level.
`timescale 1ns / 1ps

module vea_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [vea_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [vea_pkg::M_TUSER_W-1:0] m_tuser
);

    import vea_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result item changed");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] != STATUS_OK) |-> (m_tdata == '0) && !m_tuser[2])
        else $error("failed item carries nonzero result fields");

    a_found_degree: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> (m_tdata[COUNT_W-1:0] != '0))
        else $error("element found for a vertex of degree zero");

endmodule

bind vertex_element_adjacency_builder vea_checker u_vea_checker (.*);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the vertex-to-element adjacency builder.
`timescale 1ns / 1ps

module testbench;
    import vea_pkg::*;

    localparam int MAX_V = 1024;
    localparam int MAX_E = 4096;
    localparam int ITEM_TARGET = 1780;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int PRINT_LIMIT = 40;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [VERTEX_W-1:0] vertex;
        logic [RANK_W-1:0]   rank;
        logic                typed;
        logic [STATUS_W-1:0] status;
    } step_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [OP_W-1:0]        s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    vertex_element_adjacency_builder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [VERTEX_W-1:0] conn_entries [MAX_E];
    logic [ELEM_W-1:0]   adj_entries [MAX_E];
    int unsigned         vertex_offsets [MAX_V + 2];
    int unsigned         stored_count = 0;
    bit                  table_built = 1'b0;
    int unsigned         reg_vcount = VCOUNT_RESET;
    int unsigned         reg_one_based = 0;
    int unsigned         reg_npe = NPE_RESET;

    result_t     pending_results [$];
    step_t       directed_steps [25];
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned items_sent = 0;
    int unsigned stream_items = 0;
    int unsigned settings_applied = 0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;

    int unsigned preset_vcount [5] = '{1024, 2047, 0, 1, 2};
    int unsigned preset_one_based [5] = '{1, 0, 1, 0, 1};
    int unsigned preset_npe [5] = '{27, 31, 0, 1, 2};

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
    end

    function automatic int unsigned eff_vcount();
        if (reg_vcount < 1)
            return 1;
        if (reg_vcount > MAX_V)
            return MAX_V;
        return reg_vcount;
    endfunction

    function automatic int unsigned eff_npe();
        return (reg_npe < NPE_MIN) ? NPE_MIN : reg_npe;
    endfunction

    function automatic bit vertex_valid(input int unsigned v);
        return v >= reg_one_based && v < eff_vcount() + reg_one_based;
    endfunction

    // Counting sort of the whole elements by vertex into CSR offsets and element lists.
    function automatic void rebuild_adjacency();
        int unsigned top;
        int unsigned npe;
        int unsigned used;
        int unsigned v;
        int unsigned pos;
        top = eff_vcount() + reg_one_based;
        npe = eff_npe();
        used = (stored_count / npe) * npe;
        for (int i = 0; i < MAX_V + 2; i++)
            vertex_offsets[i] = 0;
        for (int unsigned i = 0; i < used; i++)
        begin
            v = conn_entries[i];
            if (vertex_valid(v))
                vertex_offsets[v + 1]++;
        end
        for (int unsigned i = 1; i <= top; i++)
            vertex_offsets[i] += vertex_offsets[i - 1];
        for (int unsigned i = 0; i < used; i++)
        begin
            v = conn_entries[i];
            if (vertex_valid(v))
            begin
                pos = vertex_offsets[v];
                if (pos < MAX_E)
                    adj_entries[pos] = ELEM_W'(i / npe);
                vertex_offsets[v] = pos + 1;
            end
        end
        for (int unsigned i = top; i > 0; i--)
            vertex_offsets[i] = vertex_offsets[i - 1];
        vertex_offsets[0] = 0;
        table_built = 1'b1;
    endfunction

    function automatic result_t compute_adjacency_result(input logic [OP_W-1:0] op,
                                                         input logic [VERTEX_W-1:0] vertex,
                                                         input logic [RANK_W-1:0] rank);
        result_t     res;
        int unsigned start;
        int unsigned deg;
        int unsigned pos;
        res = '0;
        case (op)
            OP_LOAD:
            begin
                if (!vertex_valid(vertex))
                    res.status = STATUS_RANGE;
                else if (stored_count >= MAX_E)
                    res.status = STATUS_FULL;
                else
                begin
                    conn_entries[stored_count] = vertex;
                    stored_count++;
                    table_built = 1'b0;
                end
            end
            OP_QUERY:
            begin
                if (!vertex_valid(vertex))
                    res.status = STATUS_RANGE;
                else
                begin
                    if (!table_built)
                        rebuild_adjacency();
                    start = vertex_offsets[vertex];
                    deg = vertex_offsets[vertex + 1] - start;
                    res.start_position = COUNT_W'(start);
                    res.degree = COUNT_W'(deg);
                    if (rank < deg)
                    begin
                        pos = start + rank;
                        if (pos < MAX_E)
                            res.element = adj_entries[pos];
                        res.found = 1'b1;
                    end
                end
            end
            OP_CLEAR:
            begin
                stored_count = 0;
                table_built = 1'b0;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic int unsigned draw_gap(inout bit burst);
        if ($urandom_range(0, 29) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic logic [VERTEX_W-1:0] pick_vertex();
        return VERTEX_W'(reg_one_based + $urandom_range(0, eff_vcount() - 1));
    endfunction

    function automatic logic [RANK_W-1:0] pick_rank();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return RANK_W'($urandom_range(0, 7));
        if (r < 85)
            return RANK_W'($urandom_range(0, 63));
        return RANK_W'($urandom_range(0, 4095));
    endfunction

    function automatic int unsigned draw_vcount();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(1, 32);
        if (r < 9)
            return $urandom_range(33, 1024);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 1;
            2: return 1024;
            default: return 2047;
        endcase
    endfunction

    function automatic int unsigned draw_npe();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(2, 8);
        if (r < 9)
            return $urandom_range(9, 27);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 1;
            2: return 27;
            default: return 31;
        endcase
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
                     results_seen, field, got, want);
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [VERTEX_W-1:0] vertex,
                             input logic [RANK_W-1:0] rank, input bit typed,
                             input logic [STATUS_W-1:0] typed_status);
        int unsigned gap;
        result_t     want;
        gap = draw_gap(send_burst);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {{(S_TDATA_W - VERTEX_W - RANK_W){1'b0}}, rank, vertex};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = compute_adjacency_result(op, vertex, rank);
        if (typed)
        begin
            want = '0;
            want.status = typed_status;
        end
        pending_results.insert(pending_results.size(), want);
        items_sent++;
        if (op != OP_UNUSED)
            stream_items++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_VERTEX_COUNT:
            begin
                reg_vcount = value & 32'h7FF;
                table_built = 1'b0;
            end
            CFG_ONE_BASED:
            begin
                reg_one_based = value & 32'h1;
                table_built = 1'b0;
            end
            CFG_NODES:
            begin
                reg_npe = value & 32'h1F;
                table_built = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic apply_config(input int unsigned vc, input int unsigned ob,
                                input int unsigned npe, input bit spare);
        write_reg(CFG_VERTEX_COUNT, vc);
        write_reg(CFG_ONE_BASED, ob);
        write_reg(CFG_NODES, npe);
        if (spare)
            write_reg(CFG_SPARE, $urandom_range(0, 2047));
        cfg_valid <= 1'b0;
        settings_applied++;
        @(posedge clk);
    endtask

    task automatic load_mesh(input int unsigned elements);
        for (int unsigned e = 0; e < elements; e++)
            for (int unsigned n = 0; n < eff_npe(); n++)
                send_item(OP_LOAD, ($urandom_range(0, 9) == 0) ?
                          VERTEX_W'($urandom_range(0, 2047)) : pick_vertex(),
                          RANK_W'($urandom_range(0, 4095)), 1'b0, STATUS_OK);
    endtask

    // Mostly queries on the built table, with some loads, clears and noise in between.
    task automatic stream_mixed(input int unsigned count);
        int unsigned r;
        int unsigned lo;
        int unsigned hi;
        for (int unsigned n = 0; n < count; n++)
        begin
            lo = reg_one_based;
            hi = eff_vcount() + reg_one_based - 1;
            r = $urandom_range(0, 99);
            if (r < 72)
                send_item(OP_QUERY, pick_vertex(), pick_rank(), 1'b0, STATUS_OK);
            else if (r < 80)
                send_item(OP_QUERY, VERTEX_W'($urandom_range(0, 1) ? lo : hi), pick_rank(),
                          1'b0, STATUS_OK);
            else if (r < 86)
                send_item(OP_QUERY, VERTEX_W'(($urandom_range(0, 1) || lo == 0) ?
                          hi + 1 : lo - 1), pick_rank(), 1'b0, STATUS_OK);
            else if (r < 90)
                send_item(OP_QUERY, VERTEX_W'($urandom_range(0, 2047)),
                          RANK_W'($urandom_range(0, 4095)), 1'b0, STATUS_OK);
            else if (r < 94)
                send_item(OP_LOAD, pick_vertex(), pick_rank(), 1'b0, STATUS_OK);
            else if (r < 96)
                send_item(OP_LOAD, VERTEX_W'($urandom_range(0, 2047)), pick_rank(),
                          1'b0, STATUS_OK);
            else if (r < 97)
                send_item(OP_CLEAR, VERTEX_W'($urandom_range(0, 2047)), pick_rank(),
                          1'b0, STATUS_OK);
            else
                send_item(OP_UNUSED, VERTEX_W'($urandom_range(0, 2047)),
                          RANK_W'($urandom_range(0, 4095)), 1'b0, STATUS_OK);
        end
    endtask

    initial
    begin : result_checker
        result_t     got;
        result_t     want;
        int unsigned gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(recv_burst);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            got.degree = m_tdata[COUNT_W-1:0];
            got.start_position = m_tdata[2*COUNT_W-1:COUNT_W];
            got.element = m_tdata[2*COUNT_W+ELEM_W-1:2*COUNT_W];
            got.status = m_tuser[STATUS_W-1:0];
            got.found = m_tuser[STATUS_W];
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("result with no item waiting", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.degree !== want.degree)
                    report_mismatch("degree", got.degree, want.degree);
                if (got.start_position !== want.start_position)
                    report_mismatch("start_position", got.start_position,
                                    want.start_position);
                if (got.element !== want.element)
                    report_mismatch("element", got.element, want.element);
                if (got.found !== want.found)
                    report_mismatch("found", got.found, want.found);
            end
        end
    end

    initial
    begin : stimulus
        int unsigned vc;
        int unsigned ob;
        int unsigned npe;
        int unsigned phase;
        int unsigned tail;
        directed_steps = '{
            '{OP_QUERY,  11'd0,    12'd0,    1'b1, STATUS_OK},
            '{OP_QUERY,  11'd1023, 12'd4095, 1'b1, STATUS_OK},
            '{OP_QUERY,  11'd1024, 12'd0,    1'b1, STATUS_RANGE},
            '{OP_QUERY,  11'd2047, 12'd4095, 1'b1, STATUS_RANGE},
            '{OP_LOAD,   11'd1024, 12'd0,    1'b1, STATUS_RANGE},
            '{OP_LOAD,   11'd2047, 12'd4095, 1'b1, STATUS_RANGE},
            '{OP_UNUSED, 11'd2047, 12'd4095, 1'b1, STATUS_OK},
            '{OP_CLEAR,  11'd0,    12'd0,    1'b1, STATUS_OK},
            '{OP_LOAD,   11'd0,    12'd0,    1'b1, STATUS_OK},
            '{OP_LOAD,   11'd1,    12'd0,    1'b1, STATUS_OK},
            '{OP_LOAD,   11'd2,    12'd0,    1'b1, STATUS_OK},
            '{OP_LOAD,   11'd1023, 12'd0,    1'b1, STATUS_OK},
            '{OP_LOAD,   11'd1,    12'd0,    1'b1, STATUS_OK},
            '{OP_LOAD,   11'd2,    12'd0,    1'b1, STATUS_OK},
            '{OP_LOAD,   11'd3,    12'd0,    1'b1, STATUS_OK},
            '{OP_LOAD,   11'd1023, 12'd0,    1'b1, STATUS_OK},
            '{OP_LOAD,   11'd5,    12'd0,    1'b1, STATUS_OK},
            '{OP_LOAD,   11'd5,    12'd0,    1'b1, STATUS_OK},
            '{OP_QUERY,  11'd1,    12'd0,    1'b0, STATUS_OK},
            '{OP_QUERY,  11'd1023, 12'd1,    1'b0, STATUS_OK},
            '{OP_QUERY,  11'd5,    12'd0,    1'b0, STATUS_OK},
            '{OP_QUERY,  11'd2,    12'd2,    1'b0, STATUS_OK},
            '{OP_QUERY,  11'd0,    12'd4095, 1'b0, STATUS_OK},
            '{OP_CLEAR,  11'd0,    12'd0,    1'b1, STATUS_OK},
            '{OP_QUERY,  11'd1,    12'd0,    1'b1, STATUS_OK}
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
            send_item(directed_steps[i].op, directed_steps[i].vertex, directed_steps[i].rank,
                      directed_steps[i].typed, directed_steps[i].status);

        stream_items = 0;
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase < 5)
            begin
                vc = preset_vcount[phase];
                ob = preset_one_based[phase];
                npe = preset_npe[phase];
            end
            else
            begin
                vc = draw_vcount();
                ob = $urandom_range(0, 1);
                npe = draw_npe();
            end
            settle();
            apply_config(vc, ob, npe, phase == 0);
            send_item(OP_CLEAR, VERTEX_W'($urandom_range(0, 2047)), 12'd0, 1'b0, STATUS_OK);
            load_mesh($urandom_range(1, 120 / eff_npe() + 1));
            if ($urandom_range(0, 2) == 0)
            begin
                tail = $urandom_range(1, eff_npe() - 1);
                for (int unsigned k = 0; k < tail; k++)
                    send_item(OP_LOAD, pick_vertex(), 12'd0, 1'b0, STATUS_OK);
            end
            stream_mixed($urandom_range(20, 80));
            // A new vertex range over the stored mesh can leave some entries out of range.
            if ($urandom_range(0, 1) == 1)
            begin
                settle();
                apply_config(draw_vcount(), $urandom_range(0, 1), reg_npe, 1'b0);
                stream_mixed($urandom_range(10, 40));
            end
            phase++;
        end

        settle();
        repeat (20) @(posedge clk);
        $display("Covered %0d items, %0d in the randomized part, under %0d register settings",
                 items_sent, stream_items, settings_applied);
        $display("Checked %0d results field by field, with vertex ranges changed over stored meshes",
                 results_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
src/vea_pkg.sv
src/vea_ram.sv
src/vea_ctrl.sv
src/vertex_element_adjacency_builder.sv
src/vea_checker.sv
tb/sv/testbench.sv
